>>> src/edf_sched_pkg.sv
package edf_sched_pkg;

  localparam int MaxTasksDef = 16;

  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 32;
  localparam int NumTasksW = 5;
  localparam int TimeW     = 32;
  localparam int WorkW     = 16;
  localparam int FieldIdxW = 4;
  localparam int StatusW   = 3;

  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgNumTasks = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHyper    = 1'b1;

  localparam logic [StatusW-1:0] StRun    = 3'd0;
  localparam logic [StatusW-1:0] StDone   = 3'd1;
  localparam logic [StatusW-1:0] StMiss   = 3'd2;
  localparam logic [StatusW-1:0] StHalted = 3'd3;
  localparam logic [StatusW-1:0] StLoaded = 3'd4;

  typedef struct packed {
    logic                 op;
    logic [FieldIdxW-1:0] task_index;
    logic [WorkW-1:0]     exec_time;
    logic [WorkW-1:0]     period;
  } sched_req_t;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic                 slot_busy;
    logic [FieldIdxW-1:0] slot_task;
    logic [FieldIdxW-1:0] missed_task;
    logic [TimeW-1:0]     time_slot;
  } sched_rsp_t;

  typedef enum logic [2:0] {
    SeqIdle,
    SeqCalc,
    SeqCmp,
    SeqFinish,
    SeqEmit
  } seq_state_e;

  typedef struct packed {
    logic start;
    logic calc;
    logic step;
  } unit_ctl_t;

  typedef struct packed {
    logic [WorkW-1:0] exec_time;
    logic [WorkW-1:0] period;
    logic [TimeW-1:0] next_rel;
    logic [WorkW-1:0] work;
  } task_ent_t;

  typedef struct packed {
    logic             we;
    logic [TimeW-1:0] next_rel;
    logic [WorkW-1:0] work;
  } task_wb_t;

  typedef struct packed {
    logic             miss;
    logic             have_pick;
    logic             all_done;
    logic [TimeW-1:0] pick_rel;
    logic [WorkW-1:0] pick_work;
  } scan_sum_t;

endpackage

>>> src/edf_sched_tbl.sv
module edf_sched_tbl #(
  parameter int MaxTasks = edf_sched_pkg::MaxTasksDef,
  localparam int IdxW = $clog2(MaxTasks)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             ld_we_i,
  input  logic [IdxW-1:0]                  ld_addr_i,
  input  logic [edf_sched_pkg::WorkW-1:0]  ld_exec_i,
  input  logic [edf_sched_pkg::WorkW-1:0]  ld_period_i,
  input  logic                             clr_i,
  input  logic [IdxW-1:0]                  wb_addr_i,
  input  edf_sched_pkg::task_wb_t          wb_i,
  input  logic [IdxW-1:0]                  rd_addr_i,
  output edf_sched_pkg::task_ent_t         ent_o
);
  import edf_sched_pkg::*;

  logic [WorkW-1:0] exec_mem   [MaxTasks];
  logic [WorkW-1:0] period_mem [MaxTasks];
  logic [TimeW-1:0] rel_mem    [MaxTasks];
  logic [WorkW-1:0] work_mem   [MaxTasks];

  logic [MaxTasks-1:0] vld_q;
  logic                vld_rd_q;
  logic [WorkW-1:0]    exec_rd_q;
  logic [WorkW-1:0]    period_rd_q;
  logic [TimeW-1:0]    rel_rd_q;
  logic [WorkW-1:0]    work_rd_q;

  always_ff @(posedge clk_i) begin
    if (ld_we_i) begin
      exec_mem[ld_addr_i]   <= ld_exec_i;
      period_mem[ld_addr_i] <= ld_period_i;
    end
    if (wb_i.we) begin
      rel_mem[wb_addr_i]  <= wb_i.next_rel;
      work_mem[wb_addr_i] <= wb_i.work;
    end
    exec_rd_q   <= exec_mem[rd_addr_i];
    period_rd_q <= period_mem[rd_addr_i];
    rel_rd_q    <= rel_mem[rd_addr_i];
    work_rd_q   <= work_mem[rd_addr_i];
  end

  // run state reads as zero until written after a restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (wb_i.we) begin
        vld_q[wb_addr_i] <= 1'b1;
      end
      vld_rd_q <= vld_q[rd_addr_i];
    end
  end

  always_comb begin
    ent_o.exec_time = exec_rd_q;
    ent_o.period    = period_rd_q;
    ent_o.next_rel  = vld_rd_q ? rel_rd_q : '0;
    ent_o.work      = vld_rd_q ? work_rd_q : '0;
  end

endmodule

>>> src/edf_sched_unit.sv
module edf_sched_unit #(
  parameter int MaxTasks = edf_sched_pkg::MaxTasksDef,
  localparam int IdxW = $clog2(MaxTasks)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  edf_sched_pkg::unit_ctl_t         ctl_i,
  input  logic [IdxW-1:0]                  idx_i,
  input  edf_sched_pkg::task_ent_t         ent_i,
  input  logic [edf_sched_pkg::TimeW-1:0]  time_i,
  input  logic [edf_sched_pkg::TimeW-1:0]  hyper_i,
  output edf_sched_pkg::task_wb_t          wb_o,
  output edf_sched_pkg::scan_sum_t         sum_o,
  output logic [IdxW-1:0]                  miss_idx_o,
  output logic [IdxW-1:0]                  pick_idx_o
);
  import edf_sched_pkg::*;

  // first step: release check and distance of hyperperiod to next release
  logic                    act_d, rel_d, miss_d;
  logic [TimeW-1:0]        nr_d;
  logic [WorkW-1:0]        wk_d;
  logic signed [TimeW:0]   e_d;

  logic                    act_q, rel_q, miss1_q;
  logic [TimeW-1:0]        nr_q;
  logic [WorkW-1:0]        wk_q;
  logic [WorkW-1:0]        per_q;
  logic signed [TimeW:0]   e_q;

  always_comb begin
    act_d  = ent_i.period != '0;
    rel_d  = act_d && (ent_i.next_rel == time_i);
    miss_d = rel_d && (ent_i.work != '0);
    nr_d   = rel_d ? ent_i.next_rel + TimeW'(ent_i.period) : ent_i.next_rel;
    wk_d   = rel_d ? ent_i.exec_time : ent_i.work;
    e_d    = $signed({1'b0, hyper_i}) - $signed({1'b0, ent_i.next_rel});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      rel_q   <= 1'b0;
      miss1_q <= 1'b0;
    end else if (ctl_i.calc) begin
      act_q   <= act_d;
      rel_q   <= rel_d;
      miss1_q <= miss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.calc) begin
      nr_q  <= nr_d;
      wk_q  <= wk_d;
      per_q <= ent_i.period;
      e_q   <= e_d;
    end
  end

  // second step: job count test and earliest deadline compare
  // jobs done equals hyperperiod/period when h - next_rel + (left?p:0) is in [0, p)
  logic signed [TimeW+1:0] e_x, p_x, e_plus_p;
  logic                    ge_m1, ge0, ge1, ge2;
  logic                    win_lo, win_mid, win_hi;
  logic                    wn, wp, done_np, done_p, cand, better;

  logic                    have_q, miss_q, alln_q, exc_q, best_dp_q;
  logic [IdxW-1:0]         best_idx_q, miss_idx_q;
  logic [TimeW-1:0]        best_nr_q;
  logic [WorkW-1:0]        best_wk_q;

  function automatic logic win_sel(logic r, logic w, logic lo, logic mid, logic hi);
    logic res;
    unique case ({r, w})
      2'b01:   res = lo;
      2'b10:   res = hi;
      default: res = mid;
    endcase
    return res;
  endfunction

  always_comb begin
    e_x      = {e_q[TimeW], e_q};
    p_x      = $signed({{(TimeW + 2 - WorkW){1'b0}}, per_q});
    e_plus_p = e_x + p_x;
    ge_m1    = !e_plus_p[TimeW+1];
    ge0      = !e_x[TimeW+1];
    ge1      = e_x >= p_x;
    ge2      = e_x >= (p_x <<< 1);
    win_lo   = ge_m1 && !ge0;
    win_mid  = ge0 && !ge1;
    win_hi   = ge1 && !ge2;
    wn       = wk_q != '0;
    wp       = wk_q != WorkW'(1);
    done_np  = !act_q || win_sel(rel_q, wn, win_lo, win_mid, win_hi);
    done_p   = !act_q || win_sel(rel_q, wp, win_lo, win_mid, win_hi);
    cand     = act_q && wn;
    // ties go to the later entry
    better   = cand && (!have_q || (nr_q <= best_nr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q    <= 1'b0;
      miss_q    <= 1'b0;
      alln_q    <= 1'b1;
      exc_q     <= 1'b1;
      best_dp_q <= 1'b1;
    end else if (ctl_i.start) begin
      have_q    <= 1'b0;
      miss_q    <= 1'b0;
      alln_q    <= 1'b1;
      exc_q     <= 1'b1;
      best_dp_q <= 1'b1;
    end else if (ctl_i.step) begin
      alln_q <= alln_q && done_np;
      if (miss1_q) begin
        miss_q <= 1'b1;
      end
      if (better) begin
        have_q    <= 1'b1;
        best_dp_q <= done_p;
        // the old best now counts as an unpicked task
        exc_q     <= alln_q;
      end else begin
        exc_q <= exc_q && done_np;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step) begin
      if (miss1_q) begin
        miss_idx_q <= idx_i;
      end
      if (better) begin
        best_idx_q <= idx_i;
        best_nr_q  <= nr_q;
        best_wk_q  <= wk_q;
      end
    end
  end

  always_comb begin
    wb_o.we          = rel_q;
    wb_o.next_rel    = nr_q;
    wb_o.work        = wk_q;
    sum_o.miss       = miss_q;
    sum_o.have_pick  = have_q;
    sum_o.all_done   = have_q ? (exc_q && best_dp_q) : alln_q;
    sum_o.pick_rel   = best_nr_q;
    sum_o.pick_work  = best_wk_q - WorkW'(1);
    miss_idx_o       = miss_idx_q;
    pick_idx_o       = best_idx_q;
  end

endmodule

>>> src/edf_periodic_task_scheduler_core.sv
// Earliest-deadline-first scheduler for periodic tasks. A load request writes one task entry
// (execution time, period) and restarts the run at time zero; a tick request simulates one
// time slot. Each request returns one result: slot run, all jobs done, deadline miss, halted,
// or loaded. Task tables live in small memories with one read and one write port, and a single
// evaluation unit visits the task entries one at a time, first releasing due jobs and then
// keeping the earliest deadline and the jobs-done tally. No new request is taken until the
// result of the current one sits in the output register, which holds it while the output is
// stalled. Configuration writes are taken in any cycle and must only be issued while the block
// is idle.
module edf_periodic_task_scheduler_core #(
  parameter int MaxTasks = edf_sched_pkg::MaxTasksDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  edf_sched_pkg::sched_req_t           in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output edf_sched_pkg::sched_rsp_t           out_rsp_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [edf_sched_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [edf_sched_pkg::CfgDataW-1:0]  cfg_data_i
);
  import edf_sched_pkg::*;

  localparam int IdxW = $clog2(MaxTasks);
  localparam int CntW = $clog2(MaxTasks + 1);

  seq_state_e           state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d, nxt_cnt, n_act;
  logic [TimeW-1:0]     time_q, time_d;
  logic                 halted_q, halted_d;
  logic [NumTasksW-1:0] num_tasks_q;
  logic [TimeW-1:0]     hyper_q;
  sched_rsp_t           rsp_q, rsp_d, out_q;
  logic                 out_valid_q;
  logic                 emit_ok, emit_fire, last_task;

  unit_ctl_t            ctl;
  logic                 ld_we, clr;
  logic [IdxW-1:0]      rd_addr, wb_addr, miss_idx, pick_idx;
  task_wb_t             tbl_wb, unit_wb;
  task_ent_t            ent;
  scan_sum_t            sum;

  edf_sched_tbl #(.MaxTasks(MaxTasks)) u_tbl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_we_i     (ld_we),
    .ld_addr_i   (IdxW'(in_req_i.task_index)),
    .ld_exec_i   (in_req_i.exec_time),
    .ld_period_i (in_req_i.period),
    .clr_i       (clr),
    .wb_addr_i   (wb_addr),
    .wb_i        (tbl_wb),
    .rd_addr_i   (rd_addr),
    .ent_o       (ent)
  );

  edf_sched_unit #(.MaxTasks(MaxTasks)) u_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .idx_i      (cnt_q[IdxW-1:0]),
    .ent_i      (ent),
    .time_i     (time_q),
    .hyper_i    (hyper_q),
    .wb_o       (unit_wb),
    .sum_o      (sum),
    .miss_idx_o (miss_idx),
    .pick_idx_o (pick_idx)
  );

  always_comb begin
    if (32'(num_tasks_q) > 32'(MaxTasks)) begin
      n_act = CntW'(MaxTasks);
    end else begin
      n_act = CntW'(num_tasks_q);
    end
  end

  assign nxt_cnt    = cnt_q + CntW'(1);
  assign last_task  = nxt_cnt == n_act;
  assign emit_ok    = !out_valid_q || !out_stall_i;
  assign emit_fire  = (state_q == SeqEmit) && emit_ok;
  assign in_stall_o = state_q != SeqIdle;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    time_d   = time_q;
    halted_d = halted_q;
    rsp_d    = rsp_q;
    ctl      = '0;
    ld_we    = 1'b0;
    clr      = 1'b0;
    rd_addr  = '0;
    wb_addr  = cnt_q[IdxW-1:0];
    tbl_wb   = '0;
    unique case (state_q)
      SeqIdle: begin
        if (in_valid_i) begin
          rsp_d = '0;
          if (in_req_i.op == OpLoad) begin
            ld_we        = 32'(in_req_i.task_index) < 32'(MaxTasks);
            clr          = 1'b1;
            time_d       = '0;
            halted_d     = 1'b0;
            rsp_d.status = StLoaded;
            state_d      = SeqEmit;
          end else if (halted_q) begin
            rsp_d.status    = StHalted;
            rsp_d.time_slot = time_q;
            state_d         = SeqEmit;
          end else begin
            ctl.start = 1'b1;
            cnt_d     = '0;
            state_d   = (n_act == '0) ? SeqFinish : SeqCalc;
          end
        end
      end
      SeqCalc: begin
        ctl.calc = 1'b1;
        state_d  = SeqCmp;
      end
      SeqCmp: begin
        ctl.step = 1'b1;
        tbl_wb   = unit_wb;
        if (last_task) begin
          state_d = SeqFinish;
        end else begin
          cnt_d   = nxt_cnt;
          rd_addr = nxt_cnt[IdxW-1:0];
          state_d = SeqCalc;
        end
      end
      SeqFinish: begin
        rsp_d           = '0;
        rsp_d.time_slot = time_q;
        if (sum.miss) begin
          rsp_d.status      = StMiss;
          rsp_d.missed_task = FieldIdxW'(miss_idx);
          halted_d          = 1'b1;
        end else begin
          // the picked task spends one slot of work
          wb_addr          = pick_idx;
          tbl_wb.we        = sum.have_pick;
          tbl_wb.next_rel  = sum.pick_rel;
          tbl_wb.work      = sum.pick_work;
          rsp_d.slot_busy  = sum.have_pick;
          rsp_d.slot_task  = sum.have_pick ? FieldIdxW'(pick_idx) : '0;
          rsp_d.status     = sum.all_done ? StDone : StRun;
          halted_d         = sum.all_done || (time_q == hyper_q);
          time_d           = time_q + TimeW'(1);
        end
        state_d = SeqEmit;
      end
      SeqEmit: begin
        if (emit_ok) begin
          state_d = SeqIdle;
        end
      end
      default: begin
        state_d = SeqIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SeqIdle;
      cnt_q    <= '0;
      time_q   <= '0;
      halted_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      time_q   <= time_d;
      halted_q <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (emit_fire) begin
      out_q <= rsp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_tasks_q <= NumTasksW'(1);
      hyper_q     <= TimeW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgNumTasks: num_tasks_q <= cfg_data_i[NumTasksW-1:0];
        CfgHyper:    hyper_q     <= cfg_data_i[TimeW-1:0];
        default:     hyper_q     <= hyper_q;
      endcase
    end
  end

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SeqCmp) |-> (cnt_q < n_act))
    else $error("task scan index beyond active task count");

  a_stop_report_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == SeqEmit) && ((rsp_q.status == StMiss) || (rsp_q.status == StHalted)))
      |-> halted_q)
    else $error("miss or halted result without halted run");

  a_time_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == SeqFinish) && !sum.miss) |=> (time_q == $past(time_q) + TimeW'(1)))
    else $error("time did not advance after a completed slot");

  a_wb_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_wb.we |-> ((state_q == SeqCmp) || (state_q == SeqFinish)))
    else $error("task state written outside a scan");

endmodule

>>> tb/edf_sched_checker.sv
`timescale 1ns / 100ps

module edf_sched_checker
  import edf_sched_pkg::*;
#(
  parameter int MaxTasks = MaxTasksDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  sched_req_t          in_req_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  sched_rsp_t          out_rsp_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  errors_o,
  output int                  pending_o
);

  logic [WorkW-1:0]     exec_tab [MaxTasks];
  logic [WorkW-1:0]     per_tab  [MaxTasks];
  logic [TimeW-1:0]     rel_tab  [MaxTasks];
  logic [WorkW-1:0]     work_tab [MaxTasks];
  logic [TimeW-1:0]     now_q;
  logic                 halted_q;
  logic [NumTasksW-1:0] ntasks_q;
  logic [CfgDataW-1:0]  hyper_q;
  sched_rsp_t           slot_reports_q [$];

  task automatic restart_run();
    for (int k = 0; k < MaxTasks; k++) begin
      rel_tab[k]  = '0;
      work_tab[k] = '0;
    end
    now_q    = '0;
    halted_q = 1'b0;
  endtask

  task automatic schedule_slot(input sched_req_t req, output sched_rsp_t rsp);
    int               n;
    int               pick;
    logic [TimeW-1:0] t;
    logic [TimeW-1:0] jobs;
    logic             finished;
    rsp = '0;
    n = (ntasks_q > MaxTasks) ? MaxTasks : int'(ntasks_q);
    if (req.op == OpLoad) begin
      if (req.task_index < MaxTasks) begin
        exec_tab[req.task_index] = req.exec_time;
        per_tab[req.task_index]  = req.period;
      end
      restart_run();
      rsp.status = StLoaded;
      return;
    end
    t = now_q;
    rsp.time_slot = t;
    if (halted_q) begin
      rsp.status = StHalted;
      return;
    end
    // releases go from the top index down, so the first offender is the highest one
    for (int k = n - 1; k >= 0; k--) begin
      if (per_tab[k] == 0 || rel_tab[k] != t) continue;
      if (work_tab[k] != 0) begin
        rsp.status      = StMiss;
        rsp.missed_task = k[FieldIdxW-1:0];
        halted_q        = 1'b1;
        return;
      end
      work_tab[k] = exec_tab[k];
      rel_tab[k]  = rel_tab[k] + TimeW'(per_tab[k]);
    end
    pick = -1;
    for (int j = 0; j < n; j++) begin
      if (per_tab[j] == 0 || work_tab[j] == 0) continue;
      // ties on the deadline go to the later index
      if (pick < 0 || rel_tab[j] <= rel_tab[pick]) pick = j;
    end
    if (pick >= 0) begin
      work_tab[pick] = work_tab[pick] - WorkW'(1);
      rsp.slot_busy  = 1'b1;
      rsp.slot_task  = pick[FieldIdxW-1:0];
    end
    finished = 1'b1;
    for (int j = 0; j < n; j++) begin
      if (per_tab[j] == 0) continue;
      jobs = rel_tab[j] / TimeW'(per_tab[j]);
      if (work_tab[j] != 0) jobs = jobs - TimeW'(1);
      if (jobs != hyper_q / CfgDataW'(per_tab[j])) finished = 1'b0;
    end
    if (finished) begin
      rsp.status = StDone;
      halted_q   = 1'b1;
    end else begin
      rsp.status = StRun;
      if (t == hyper_q) halted_q = 1'b1;
    end
    now_q = t + TimeW'(1);
  endtask

  task automatic field_check(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sched_rsp_t want;
    sched_rsp_t got;
    if (!rst_ni) begin
      slot_reports_q.delete();
      restart_run();
      ntasks_q = NumTasksW'(1);
      hyper_q  = CfgDataW'(1);
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_rsp_i;
        if (slot_reports_q.size() == 0) begin
          $display("%0t: result with none pending: expected nothing, got %p", $time, got);
          errors_o++;
        end else begin
          want = slot_reports_q.pop_front();
          field_check("status", 32'(want.status), 32'(got.status));
          field_check("slot_busy", 32'(want.slot_busy), 32'(got.slot_busy));
          field_check("slot_task", 32'(want.slot_task), 32'(got.slot_task));
          field_check("missed_task", 32'(want.missed_task), 32'(got.missed_task));
          field_check("time_slot", 32'(want.time_slot), 32'(got.time_slot));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgNumTasks: ntasks_q = cfg_data_i[NumTasksW-1:0];
          CfgHyper:    hyper_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        schedule_slot(in_req_i, want);
        slot_reports_q.push_back(want);
      end
    end
    pending_o = slot_reports_q.size();
  end

endmodule

>>> tb/tb_edf_periodic_task_scheduler_core.sv
`timescale 1ns / 100ps

module tb_edf_periodic_task_scheduler_core;
  import edf_sched_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 40;
  localparam int TargetItems  = 525;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  sched_req_t          in_req_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  sched_rsp_t          out_rsp_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  int errors;
  int pending;
  int items_sent  = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int cycle_count = 0;

  edf_periodic_task_scheduler_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  edf_sched_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_i   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_request(input logic req_op, input logic [FieldIdxW-1:0] idx,
                              input logic [WorkW-1:0] exec_t, input logic [WorkW-1:0] per);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{op: req_op, task_index: idx, exec_time: exec_t, period: per};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic tick_slot();
    // fields other than op are ignored on a tick, so they carry noise
    push_request(OpTick, FieldIdxW'($urandom_range(0, 15)), WorkW'($urandom_range(0, 65535)),
                 WorkW'($urandom_range(0, 65535)));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [NumTasksW-1:0] n, input logic [CfgDataW-1:0] h);
    settle();
    write_reg(CfgNumTasks, CfgDataW'(n));
    write_reg(CfgHyper, h);
  endtask

  initial begin
    int                   scen;
    int                   n_eff;
    int                   lcm;
    int                   a;
    int                   b;
    int                   rem;
    int                   k;
    int                   slots;
    logic [NumTasksW-1:0] n_cfg;
    logic [CfgDataW-1:0]  hyper;
    logic [WorkW-1:0]     per_sel  [16];
    logic [WorkW-1:0]     exec_sel [16];

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // feasible pair: completes inside the hyperperiod, then a halted tick
    configure(2, 6);
    push_request(OpLoad, 0, 1, 2);
    push_request(OpLoad, 1, 1, 3);
    repeat (6) tick_slot();
    // overloaded pair: task 1 misses, then halted
    push_request(OpLoad, 1, 3, 3);
    repeat (5) tick_slot();
    // equal deadlines
    push_request(OpLoad, 1, 1, 2);
    repeat (2) tick_slot();
    push_request(OpLoad, 15, 16'hFFFF, 16'hFFFF);
    // no active tasks: first tick finishes the run
    configure(0, 32'hFFFF_FFFF);
    push_request(OpLoad, 14, 0, 0);
    tick_slot();
    // zero execution time, then zero period
    configure(1, 2);
    push_request(OpLoad, 0, 0, 1);
    repeat (2) tick_slot();
    push_request(OpLoad, 0, 5, 0);
    tick_slot();

    scen = 0;
    while (items_sent < TargetItems) begin
      case (scen % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      if (scen > 0 && $urandom_range(0, 4) == 0) begin
        // mixed loads and ticks on the current configuration
        repeat (12) begin
          if ($urandom_range(0, 2) == 0) begin
            push_request(OpLoad, FieldIdxW'($urandom_range(0, 15)),
                         WorkW'($urandom_range(0, 65535)), WorkW'($urandom_range(0, 65535)));
          end else begin
            tick_slot();
          end
        end
      end else begin
        case ($urandom_range(0, 9))
          0:       n_cfg = 0;
          1:       n_cfg = NumTasksW'($urandom_range(17, 31));
          2:       n_cfg = 16;
          default: n_cfg = NumTasksW'($urandom_range(1, 6));
        endcase
        n_eff = (n_cfg > 16) ? 16 : int'(n_cfg);
        lcm = 1;
        for (int i = 0; i < n_eff; i++) begin
          case ($urandom_range(0, 6))
            0:       per_sel[i] = 1;
            1:       per_sel[i] = 2;
            2:       per_sel[i] = 3;
            3:       per_sel[i] = 4;
            4:       per_sel[i] = 6;
            5:       per_sel[i] = 8;
            default: per_sel[i] = 12;
          endcase
          if ($urandom_range(0, 2) < 2) begin
            exec_sel[i] = WorkW'($urandom_range(1, (per_sel[i] + 2) / 3));
          end else begin
            exec_sel[i] = WorkW'($urandom_range(0, per_sel[i]));
          end
          if ($urandom_range(0, 15) == 0) per_sel[i] = 0;
          if (per_sel[i] != 0) begin
            a = lcm;
            b = per_sel[i];
            while (b != 0) begin
              rem = a % b;
              a   = b;
              b   = rem;
            end
            lcm = lcm / a * per_sel[i];
          end
        end
        // one entry with wide random values, kept out of the hyperperiod
        if (n_eff > 0 && $urandom_range(0, 3) == 0) begin
          k = $urandom_range(0, n_eff - 1);
          exec_sel[k] = WorkW'($urandom_range(0, 65535));
          per_sel[k]  = WorkW'($urandom_range(0, 65535));
        end
        case ($urandom_range(0, 9))
          0:       hyper = $urandom_range(1, lcm);
          1:       hyper = $urandom;
          2:       hyper = 32'hFFFF_FFFF;
          3:       hyper = lcm * 2;
          default: hyper = lcm;
        endcase
        configure(n_cfg, hyper);
        if (n_eff < 16 && $urandom_range(0, 2) == 0) begin
          push_request(OpLoad, FieldIdxW'($urandom_range(n_eff, 15)),
                       WorkW'($urandom_range(0, 65535)), WorkW'($urandom_range(0, 65535)));
        end
        for (int i = 0; i < n_eff; i++) begin
          push_request(OpLoad, FieldIdxW'(i), exec_sel[i], per_sel[i]);
        end
        // let everything drain once before the run starts
        if (scen == 3) settle();
        slots = (hyper > 26) ? 26 : int'(hyper);
        repeat (slots + $urandom_range(1, 3)) tick_slot();
      end
      scen++;
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
